[rtl/lfp_pkg.sv]
// ----------------------------------------------------------------------------
// lfp_pkg
// shared types and constants of the 6lowpan fragment planner
// ----------------------------------------------------------------------------
package lfp_pkg;

   localparam int MAX_FRAGMENTS_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [6:0] MTU_RESET = 7'd127;
   localparam logic [7:0] DISPATCH_FIRST = 8'hc0;
   localparam logic [7:0] DISPATCH_NEXT = 8'he0;
   localparam logic [2:0] FIRST_HEAD = 3'd4;
   localparam logic [2:0] NEXT_HEAD = 3'd5;

   typedef enum logic [1:0] {
      KIND_WHOLE = 2'd0,
      KIND_FIRST = 2'd1,
      KIND_NEXT  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [10:0] frame_length;
      logic [15:0] tag;
      logic [2:0]  size_high;
      logic [7:0]  size_low;
      logic [10:0] first_length;
      logic [10:0] payload;
      logic [10:0] datagram_offset;
      logic [6:0]  next_budget;
      logic        first_last;
   } job_type;

endpackage

[rtl/lfp_ifs.sv]
// ----------------------------------------------------------------------------
// lfp channel interfaces
// valid/ready channels for packet descriptors and fragment descriptors
// ----------------------------------------------------------------------------
interface lfp_req_if;
   logic        valid;
   logic        ready;
   logic [10:0] frame_length;
   logic [5:0]  mac_header_length;
   logic [5:0]  compressed_header_length;
   logic [10:0] uncompressed_total;
   logic [6:0]  uncompressed_header_length;

   modport source (
      output valid, frame_length, mac_header_length, compressed_header_length,
             uncompressed_total, uncompressed_header_length,
      input  ready
   );
   modport sink (
      input  valid, frame_length, mac_header_length, compressed_header_length,
             uncompressed_total, uncompressed_header_length,
      output ready
   );
endinterface

interface lfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_kind;
   logic [7:0]  dispatch_byte;
   logic [7:0]  size_low_byte;
   logic [15:0] datagram_tag;
   logic [7:0]  offset_units;
   logic [2:0]  fragment_header_length;
   logic [10:0] source_offset;
   logic [10:0] copy_length;
   logic        last;

   modport source (
      output valid, frame_kind, dispatch_byte, size_low_byte, datagram_tag,
             offset_units, fragment_header_length, source_offset,
             copy_length, last,
      input  ready
   );
   modport sink (
      input  valid, frame_kind, dispatch_byte, size_low_byte, datagram_tag,
             offset_units, fragment_header_length, source_offset,
             copy_length, last,
      output ready
   );
endinterface

[rtl/lowpan_fragment_planner_unit.sv]
// ----------------------------------------------------------------------------
// lowpan_fragment_planner_unit
// plans the 6lowpan fragmentation of outgoing frames
// ----------------------------------------------------------------------------
// Each packet descriptor yields one whole-frame or error transaction, or a
// first-fragment transaction followed by subsequent-fragment transactions
// (at most MAX_FRAGMENTS in all). The classifier registers each descriptor
// once in its stage-one registers and pushes it into a two-entry job queue
// when that queue is not full, taking one descriptor per cycle unless the
// queue is full; the first result of a packet is offered once it has passed
// the stage-one registers, the job queue and the output registers. The emitter
// puts out one transaction per cycle while the response channel is ready. The
// user must write frame_mtu through the csr port only while no packet is in
// flight; the block itself does not enforce this.
module lowpan_fragment_planner_unit #(
   parameter int MAX_FRAGMENTS = lfp_pkg::MAX_FRAGMENTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   lfp_req_if.sink    req_ch,
   lfp_rsp_if.source  rsp_ch,
   input  logic       csr_write_enable,
   input  logic [6:0] csr_write_data
);

   logic [6:0]       frame_mtu_ff, frame_mtu_in;
   logic             push;
   logic             full;
   logic             pop;
   logic             empty;
   lfp_pkg::job_type push_job;
   lfp_pkg::job_type head_job;

   assign frame_mtu_in = csr_write_enable ? csr_write_data : frame_mtu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mtu_ff <= lfp_pkg::MTU_RESET;
      end else begin
         frame_mtu_ff <= frame_mtu_in;
      end
   end

   lfp_front #(
      .MAX_FRAGMENTS (MAX_FRAGMENTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .frame_mtu (frame_mtu_ff),
      .req       (req_ch),
      .push      (push),
      .push_job  (push_job),
      .full      (full)
   );

   lfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty)
   );

   lfp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .head_job (head_job),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

endmodule

[rtl/lfp_front.sv]
// ----------------------------------------------------------------------------
// lfp_front
// accepts packet descriptors, computes budgets and classifies each packet
// ----------------------------------------------------------------------------
module lfp_front #(
   parameter int MAX_FRAGMENTS = lfp_pkg::MAX_FRAGMENTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [6:0]        frame_mtu,
   lfp_req_if.sink           req,
   output logic              push,
   output lfp_pkg::job_type  push_job,
   input  logic              full
);

   localparam int CNT_W = $clog2(MAX_FRAGMENTS);
   localparam int CMP_W = CNT_W + 12;
   localparam logic [CNT_W-1:0] MAX_LESS_ONE = CNT_W'(MAX_FRAGMENTS - 1);

   logic               accept;
   logic signed [9:0]  first_budget;
   logic signed [9:0]  next_budget;
   logic               bad;
   logic               whole;

   logic               s1_valid_ff, s1_valid_in;
   logic               whole_ff;
   logic               bad_ff;
   logic [6:0]         b1_ff;
   logic [6:0]         bn_ff;
   logic [10:0]        payload_ff;
   logic [5:0]         lsize_ff;
   logic [6:0]         uhdr_ff;
   logic [10:0]        dsize_ff;
   logic [10:0]        flen_ff;
   logic [15:0]        tag_ff, tag_in;

   logic [10:0]        first_len;
   logic signed [11:0] remain;
   logic [CNT_W+6:0]   limit;
   logic               over;

   assign push = s1_valid_ff && !full;
   assign req.ready = !s1_valid_ff || !full;
   assign accept = req.valid && req.ready;

   // stage one: budgets and early checks
   always_comb begin
      first_budget = $signed({3'b000, frame_mtu}) - $signed({4'b0000, req.mac_header_length})
                   - $signed({4'b0000, req.compressed_header_length}) - 10'sd6;
      next_budget = $signed({3'b000, frame_mtu}) - $signed({4'b0000, req.mac_header_length})
                  - 10'sd7;
      bad = first_budget[9] || (next_budget < 10'sd8)
          || (req.frame_length < {5'b00000, req.mac_header_length});
      whole = ({1'b0, req.frame_length} + 12'd2) <= {5'b00000, frame_mtu};
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         whole_ff   <= whole;
         bad_ff     <= bad;
         b1_ff      <= {first_budget[6:3], 3'b000};
         bn_ff      <= {next_budget[6:3], 3'b000};
         payload_ff <= req.frame_length - {5'b00000, req.mac_header_length};
         lsize_ff   <= req.compressed_header_length;
         uhdr_ff    <= req.uncompressed_header_length;
         dsize_ff   <= req.uncompressed_total - {5'b00000, req.mac_header_length};
         flen_ff    <= req.frame_length;
      end
   end

   // stage two: fragment count check and job assembly
   always_comb begin
      first_len = {5'b00000, lsize_ff} + {4'b0000, b1_ff};
      remain = $signed({1'b0, payload_ff}) - $signed({1'b0, first_len});
      limit = MAX_LESS_ONE * bn_ff;
      over = !remain[11] && (CMP_W'(remain[10:0]) > CMP_W'(limit));

      push_job.frame_length = flen_ff;
      push_job.tag = tag_ff;
      push_job.size_high = dsize_ff[10:8];
      push_job.size_low = dsize_ff[7:0];
      push_job.first_length = first_len;
      push_job.payload = payload_ff;
      push_job.datagram_offset = {4'b0000, uhdr_ff} + {4'b0000, b1_ff};
      push_job.next_budget = bn_ff;
      push_job.first_last = remain[11] || (remain == 12'sd0);
      if (whole_ff) begin
         push_job.kind = lfp_pkg::KIND_WHOLE;
      end else if (bad_ff || over) begin
         push_job.kind = lfp_pkg::KIND_ERROR;
      end else begin
         push_job.kind = lfp_pkg::KIND_FIRST;
      end
   end

   always_comb begin
      tag_in = tag_ff;
      if (push && !whole_ff) begin
         tag_in = tag_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= 16'd0;
      end else begin
         tag_ff <= tag_in;
      end
   end

endmodule

[rtl/lfp_queue.sv]
// ----------------------------------------------------------------------------
// lfp_queue
// short job queue between the classifier and the fragment emitter
// ----------------------------------------------------------------------------
module lfp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lfp_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output lfp_pkg::job_type  head_job,
   output logic              empty
);

   localparam int PTR_W = $clog2(lfp_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(lfp_pkg::QUEUE_DEPTH + 1);

   lfp_pkg::job_type entry_ff [lfp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = count_ff == CNT_W'(lfp_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(lfp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(lfp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/lfp_back.sv]
// ----------------------------------------------------------------------------
// lfp_back
// walks one job and emits its fragment descriptors, one per cycle while the response channel is ready
// ----------------------------------------------------------------------------
module lfp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  lfp_pkg::job_type  head_job,
   output logic              pop,
   lfp_rsp_if.source         rsp
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_NEXT = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;
   logic        out_free;
   logic        emit_next;
   logic        load;
   logic [10:0] rem;
   logic [10:0] len;
   logic        next_last;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  disp_ff, disp_in;
   logic [7:0]  lo_ff, lo_in;
   logic [15:0] tag_ff, tag_in;
   logic [7:0]  units_ff, units_in;
   logic [2:0]  hlen_ff, hlen_in;
   logic [10:0] src_ff, src_in;
   logic [10:0] plen_ff, plen_in;
   logic        last_ff, last_in;

   logic [2:0]  cur_hi_ff, cur_hi_in;
   logic [7:0]  cur_lo_ff, cur_lo_in;
   logic [15:0] cur_tag_ff, cur_tag_in;
   logic [10:0] payload_ff, payload_in;
   logic [6:0]  bn_ff, bn_in;
   logic [10:0] emit_offset_ff, emit_offset_in;
   logic [10:0] datagram_offset_ff, datagram_offset_in;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign pop = (state_ff == ST_IDLE) && !empty && out_free;
   assign emit_next = (state_ff == ST_NEXT) && out_free;
   assign load = pop || emit_next;

   assign rem = payload_ff - emit_offset_ff;
   assign next_last = rem <= {4'b0000, bn_ff};
   assign len = next_last ? rem : {4'b0000, bn_ff};

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      disp_in = disp_ff;
      lo_in = lo_ff;
      tag_in = tag_ff;
      units_in = units_ff;
      hlen_in = hlen_ff;
      src_in = src_ff;
      plen_in = plen_ff;
      last_in = last_ff;
      cur_hi_in = cur_hi_ff;
      cur_lo_in = cur_lo_ff;
      cur_tag_in = cur_tag_ff;
      payload_in = payload_ff;
      bn_in = bn_ff;
      emit_offset_in = emit_offset_ff;
      datagram_offset_in = datagram_offset_ff;

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               kind_in = head_job.kind;
               disp_in = 8'd0;
               lo_in = 8'd0;
               tag_in = 16'd0;
               units_in = 8'd0;
               hlen_in = 3'd0;
               src_in = 11'd0;
               plen_in = 11'd0;
               last_in = 1'b1;
               case (head_job.kind)
                  lfp_pkg::KIND_WHOLE: begin
                     plen_in = head_job.frame_length;
                  end
                  lfp_pkg::KIND_FIRST: begin
                     disp_in = lfp_pkg::DISPATCH_FIRST | {5'b00000, head_job.size_high};
                     lo_in = head_job.size_low;
                     tag_in = head_job.tag;
                     hlen_in = lfp_pkg::FIRST_HEAD;
                     plen_in = head_job.first_length;
                     last_in = head_job.first_last;
                     cur_hi_in = head_job.size_high;
                     cur_lo_in = head_job.size_low;
                     cur_tag_in = head_job.tag;
                     payload_in = head_job.payload;
                     bn_in = head_job.next_budget;
                     emit_offset_in = head_job.first_length;
                     datagram_offset_in = head_job.datagram_offset;
                     if (!head_job.first_last) begin
                        state_in = ST_NEXT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_NEXT: begin
            if (emit_next) begin
               kind_in = lfp_pkg::KIND_NEXT;
               disp_in = lfp_pkg::DISPATCH_NEXT | {5'b00000, cur_hi_ff};
               lo_in = cur_lo_ff;
               tag_in = cur_tag_ff;
               units_in = datagram_offset_ff[10:3];
               hlen_in = lfp_pkg::NEXT_HEAD;
               src_in = emit_offset_ff;
               plen_in = len;
               last_in = next_last;
               emit_offset_in = emit_offset_ff + len;
               datagram_offset_in = datagram_offset_ff + len;
               if (next_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff            <= kind_in;
      disp_ff            <= disp_in;
      lo_ff              <= lo_in;
      tag_ff             <= tag_in;
      units_ff           <= units_in;
      hlen_ff            <= hlen_in;
      src_ff             <= src_in;
      plen_ff            <= plen_in;
      last_ff            <= last_in;
      cur_hi_ff          <= cur_hi_in;
      cur_lo_ff          <= cur_lo_in;
      cur_tag_ff         <= cur_tag_in;
      payload_ff         <= payload_in;
      bn_ff              <= bn_in;
      emit_offset_ff     <= emit_offset_in;
      datagram_offset_ff <= datagram_offset_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.frame_kind = kind_ff;
   assign rsp.dispatch_byte = disp_ff;
   assign rsp.size_low_byte = lo_ff;
   assign rsp.datagram_tag = tag_ff;
   assign rsp.offset_units = units_ff;
   assign rsp.fragment_header_length = hlen_ff;
   assign rsp.source_offset = src_ff;
   assign rsp.copy_length = plen_ff;
   assign rsp.last = last_ff;

endmodule
